// ===== rtl/q4_temperature_to_ascii_record_unit_macros.svh =====
// ----------------------------------------------------------------------------
// q4 temperature to ascii record unit, assertion macros
// shared property shorthands for the port checker
// ----------------------------------------------------------------------------
`ifndef Q4_TEMPERATURE_TO_ASCII_RECORD_UNIT_MACROS_SVH
`define Q4_TEMPERATURE_TO_ASCII_RECORD_UNIT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define Q4TA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define Q4TA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/q4ta_pkg.sv =====
// ----------------------------------------------------------------------------
// q4ta_pkg
// constants and tables for the q4 temperature to ascii record unit
// ----------------------------------------------------------------------------
`default_nettype none

package q4ta_pkg;

    localparam int unsigned TEMP_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned INT_W      = 12;   // integer part, max 2048
    localparam int unsigned BCD_DIGITS = 4;
    localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
    localparam int unsigned PREFIX_LEN = 23;
    localparam int unsigned PIDX_W     = $clog2(PREFIX_LEN);
    localparam int unsigned STEP_W     = $clog2(INT_W);

    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_DOT   = 8'h2E;
    localparam t_byte CH_RBRACE = 8'h7D;
    localparam t_byte CH_LF    = 8'h0A;

    // {"code":"data","value":
    function automatic t_byte prefix_char(input logic [PIDX_W-1:0] idx);
        t_byte ch;
        case (idx)
            5'd0:    ch = 8'h7B;
            5'd1:    ch = 8'h22;
            5'd2:    ch = 8'h63;
            5'd3:    ch = 8'h6F;
            5'd4:    ch = 8'h64;
            5'd5:    ch = 8'h65;
            5'd6:    ch = 8'h22;
            5'd7:    ch = 8'h3A;
            5'd8:    ch = 8'h22;
            5'd9:    ch = 8'h64;
            5'd10:   ch = 8'h61;
            5'd11:   ch = 8'h74;
            5'd12:   ch = 8'h61;
            5'd13:   ch = 8'h22;
            5'd14:   ch = 8'h2C;
            5'd15:   ch = 8'h22;
            5'd16:   ch = 8'h76;
            5'd17:   ch = 8'h61;
            5'd18:   ch = 8'h6C;
            5'd19:   ch = 8'h75;
            5'd20:   ch = 8'h65;
            5'd21:   ch = 8'h22;
            5'd22:   ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // (nibble * 625 + 50) / 100 as two ascii digits {tens, ones}
    function automatic logic [2*BYTE_W-1:0] hundredths_chars(input logic [3:0] nib);
        logic [7:0] hund;
        case (nib)
            4'd0:    hund = 8'h00;
            4'd1:    hund = 8'h06;
            4'd2:    hund = 8'h13;
            4'd3:    hund = 8'h19;
            4'd4:    hund = 8'h25;
            4'd5:    hund = 8'h31;
            4'd6:    hund = 8'h38;
            4'd7:    hund = 8'h44;
            4'd8:    hund = 8'h50;
            4'd9:    hund = 8'h56;
            4'd10:   hund = 8'h63;
            4'd11:   hund = 8'h69;
            4'd12:   hund = 8'h75;
            4'd13:   hund = 8'h81;
            4'd14:   hund = 8'h88;
            default: hund = 8'h94;
        endcase
        // hund holds two bcd digits
        return {CH_ZERO | {4'h0, hund[7:4]}, CH_ZERO | {4'h0, hund[3:0]}};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/q4_temperature_to_ascii_record_unit.sv =====
// ----------------------------------------------------------------------------
// q4_temperature_to_ascii_record_unit
// formats a signed q4 temperature as ascii text, one byte per beat
// ----------------------------------------------------------------------------
// usage
//   input: pulse start with i_temperature_q4 while busy is low; the item is
//   taken at that edge and busy stays high until the last byte is issued
//   output: each text byte is shown for exactly one cycle with o_out_strobe
//   high; o_last_byte marks the final byte. the receiver cannot stall, so
//   every strobed beat is taken at the edge that ends its cycle
//   config: i_cfg_we / i_cfg_wdata set wrap_record (reset 1); write it only
//   while idle. 1 wraps the number as {"code":"data","value":<num>}\n
//   timing: binary to bcd conversion on a shared shift/add-3 unit, then
//   the leading digit search, then one byte per cycle. the text is 4..8
//   bytes plain or 29..33 wrapped; the last byte shows in the first cycle
//   with busy low, so the next start is taken no earlier than that cycle
//   reset: synchronous active low; returns idle, drops the strobe and sets
//   wrap_record to 1
// ----------------------------------------------------------------------------
`default_nettype none

module q4_temperature_to_ascii_record_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // command channel
    input  wire logic                                   start,
    output      logic                                   busy,
    input  wire logic signed [q4ta_pkg::TEMP_W-1:0]     i_temperature_q4,
    // config register
    input  wire logic                                   i_cfg_we,
    input  wire logic                                   i_cfg_wdata,
    // result beats
    output      logic                                   o_out_strobe,
    output      logic [q4ta_pkg::BYTE_W-1:0]            o_out_byte,
    output      logic                                   o_last_byte
);

    // sequencer phases
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CONV  = 4'd1;   // double dabble steps
    localparam logic [3:0] ST_LEAD  = 4'd2;   // find leading digit
    localparam logic [3:0] ST_PRE   = 4'd3;   // record prefix
    localparam logic [3:0] ST_SIGN  = 4'd4;
    localparam logic [3:0] ST_INT   = 4'd5;   // integer digits
    localparam logic [3:0] ST_DOT   = 4'd6;
    localparam logic [3:0] ST_H1    = 4'd7;
    localparam logic [3:0] ST_H2    = 4'd8;
    localparam logic [3:0] ST_BRACE = 4'd9;
    localparam logic [3:0] ST_NL    = 4'd10;

    localparam logic [q4ta_pkg::STEP_W-1:0] LAST_STEP =
        q4ta_pkg::STEP_W'(q4ta_pkg::INT_W - 1);
    localparam logic [q4ta_pkg::PIDX_W-1:0] LAST_PIDX =
        q4ta_pkg::PIDX_W'(q4ta_pkg::PREFIX_LEN - 1);

    logic [3:0]                      r_state, n_state;
    logic                            r_wrap;        // config register
    logic                            r_item_wrap;   // wrap mode of current item
    logic                            r_neg;
    logic [q4ta_pkg::INT_W-1:0]      r_bin;
    logic [3:0]                      r_nib;
    logic [q4ta_pkg::BCD_W-1:0]      r_bcd;
    logic [q4ta_pkg::STEP_W-1:0]     r_step;
    logic [q4ta_pkg::PIDX_W-1:0]     r_pidx;
    logic [1:0]                      r_dp;          // digit pointer, msd first

    logic                            r_out_strobe, n_out_strobe;
    q4ta_pkg::t_byte                 r_out_byte, n_out_byte;
    logic                            r_out_last, n_out_last;

    logic [q4ta_pkg::TEMP_W-1:0]     mag;
    logic [q4ta_pkg::BCD_W-1:0]      bcd_adj;
    logic [1:0]                      lead_dp;
    logic [3:0]                      int_digit;
    logic [2*q4ta_pkg::BYTE_W-1:0]   hund_chars;
    logic                            accept;

    assign accept = start && (r_state == ST_IDLE);

    // magnitude; the most negative code gives 0x8000 which is still right
    assign mag = i_temperature_q4[q4ta_pkg::TEMP_W-1]
               ? (~i_temperature_q4 + 16'd1) : i_temperature_q4;

    // shared shift/add-3 unit: correct each bcd digit before the shift
    always_comb begin
        for (int d = 0; d < q4ta_pkg::BCD_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5)
                              ? (r_bcd[4*d +: 4] + 4'd3) : r_bcd[4*d +: 4];
        end
    end

    // leading nonzero digit, at least one digit always printed
    always_comb begin
        if (r_bcd[15:12] != 4'd0) begin
            lead_dp = 2'd3;
        end else if (r_bcd[11:8] != 4'd0) begin
            lead_dp = 2'd2;
        end else if (r_bcd[7:4] != 4'd0) begin
            lead_dp = 2'd1;
        end else begin
            lead_dp = 2'd0;
        end
    end

    assign int_digit  = r_bcd[4*r_dp +: 4];
    assign hund_chars = q4ta_pkg::hundredths_chars(r_nib);

    // sequencer and byte select
    always_comb begin
        n_state      = r_state;
        n_out_strobe = 1'b0;
        n_out_byte   = r_out_byte;
        n_out_last   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_LEAD;
                end
            end
            ST_LEAD: begin
                if (r_item_wrap) begin
                    n_state = ST_PRE;
                end else if (r_neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_INT;
                end
            end
            ST_PRE: begin
                n_out_strobe = 1'b1;
                n_out_byte   = q4ta_pkg::prefix_char(r_pidx);
                if (r_pidx == LAST_PIDX) begin
                    n_state = r_neg ? ST_SIGN : ST_INT;
                end
            end
            ST_SIGN: begin
                n_out_strobe = 1'b1;
                n_out_byte   = q4ta_pkg::CH_MINUS;
                n_state      = ST_INT;
            end
            ST_INT: begin
                n_out_strobe = 1'b1;
                n_out_byte   = q4ta_pkg::CH_ZERO | {4'h0, int_digit};
                if (r_dp == 2'd0) begin
                    n_state = ST_DOT;
                end
            end
            ST_DOT: begin
                n_out_strobe = 1'b1;
                n_out_byte   = q4ta_pkg::CH_DOT;
                n_state      = ST_H1;
            end
            ST_H1: begin
                n_out_strobe = 1'b1;
                n_out_byte   = hund_chars[2*q4ta_pkg::BYTE_W-1:q4ta_pkg::BYTE_W];
                n_state      = ST_H2;
            end
            ST_H2: begin
                n_out_strobe = 1'b1;
                n_out_byte   = hund_chars[q4ta_pkg::BYTE_W-1:0];
                n_out_last   = !r_item_wrap;
                n_state      = r_item_wrap ? ST_BRACE : ST_IDLE;
            end
            ST_BRACE: begin
                n_out_strobe = 1'b1;
                n_out_byte   = q4ta_pkg::CH_RBRACE;
                n_state      = ST_NL;
            end
            ST_NL: begin
                n_out_strobe = 1'b1;
                n_out_byte   = q4ta_pkg::CH_LF;
                n_out_last   = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wrap       <= 1'b1;
            r_out_strobe <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_strobe <= n_out_strobe;
            r_out_last   <= n_out_last;
            if (i_cfg_we) begin
                r_wrap <= i_cfg_wdata;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        if (accept) begin
            r_item_wrap <= r_wrap;
            r_neg       <= i_temperature_q4[q4ta_pkg::TEMP_W-1];
            r_bin       <= mag[q4ta_pkg::TEMP_W-1:4];
            r_nib       <= mag[3:0];
            r_bcd       <= '0;
            r_step      <= '0;
        end else if (r_state == ST_CONV) begin
            {r_bcd, r_bin} <= {bcd_adj, r_bin} << 1;
            r_step         <= r_step + 1'b1;
        end
        if (r_state == ST_LEAD) begin
            r_dp   <= lead_dp;
            r_pidx <= '0;
        end else if (r_state == ST_PRE) begin
            r_pidx <= r_pidx + 1'b1;
        end else if (r_state == ST_INT) begin
            r_dp <= r_dp - 1'b1;
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_out_strobe = r_out_strobe;
    assign o_out_byte   = r_out_byte;
    assign o_last_byte  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/q4ta_checker.sv =====
// ----------------------------------------------------------------------------
// q4ta_checker
// port-level checks for the q4 temperature to ascii record unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "q4_temperature_to_ascii_record_unit_macros.svh"

module q4ta_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_out_strobe,
    input wire logic [q4ta_pkg::BYTE_W-1:0]   o_out_byte,
    input wire logic                          o_last_byte
);

    logic end_beat;
    logic mid_beat;

    assign end_beat = o_out_strobe && o_last_byte && (o_out_byte != 8'h00);
    assign mid_beat = o_out_strobe && !o_last_byte;

    // last flag only rides on a strobed beat
    `Q4TA_ASSERT_SAME(a_last_has_strobe, i_clk, i_rst_n, o_last_byte, o_out_strobe, "last without strobe")
    // an accepted command holds the unit busy
    `Q4TA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "not busy after accept")
    // no beat right after an accept: conversion comes first
    `Q4TA_ASSERT_NEXT(a_accept_quiet, i_clk, i_rst_n, start && !busy, !o_out_strobe, "beat after accept")
    // final beat shows once the sequencer is idle again
    `Q4TA_ASSERT_SAME(a_end_idle, i_clk, i_rst_n, end_beat, !busy, "busy on final beat")
    // any other beat is followed by more work
    `Q4TA_ASSERT_SAME(a_mid_busy, i_clk, i_rst_n, mid_beat, busy, "idle during record")

endmodule

bind q4_temperature_to_ascii_record_unit q4ta_checker u_q4ta_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_out_strobe (o_out_strobe),
    .o_out_byte   (o_out_byte),
    .o_last_byte  (o_last_byte)
);

`default_nettype wire

// ===== tb/q4_temperature_to_ascii_record_unit_tb.sv =====
// ----------------------------------------------------------------------------
// q4_temperature_to_ascii_record_unit_tb
// self-checking bench for the q4 temperature to ascii text formatter
// ----------------------------------------------------------------------------
// drives signed q4 temperatures through the start/busy command port and
// checks every strobed text byte, and the flag on its final byte, against a
// local formatter. a short directed table covers the extremes, both record
// framings, negative inputs and several hundredths nibbles; random phases
// follow, each with its own wrap setting and its own idling pattern.
// ----------------------------------------------------------------------------

module q4_temperature_to_ascii_record_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int NUM_ROWS       = 24;
    localparam int RANDOM_PHASES  = 6;
    localparam int ITEMS_PER_PHASE = 18;
    // long enough for a full record to leave the block
    localparam int SETTLE_CYCLES  = 60;
    // the longest correct stretch without any beat is far shorter than this limit
    localparam int WATCHDOG_LIMIT = 1000;

    // one text byte as it should leave the block
    typedef struct packed {
        q4ta_pkg::t_byte ch;
        logic            last;
    } t_text_beat;

    // directed stimulus; an empty text means the formatter below decides
    typedef struct {
        logic                               wrap;
        logic signed [q4ta_pkg::TEMP_W-1:0] temp;
        string                              text;
    } t_directed_row;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic signed [q4ta_pkg::TEMP_W-1:0] i_temperature_q4;
    logic                               i_cfg_we;
    logic                               i_cfg_wdata;
    logic                               o_out_strobe;
    logic [q4ta_pkg::BYTE_W-1:0]        o_out_byte;
    logic                               o_last_byte;

    // bench copy of the wrap_record register
    logic            wrap_now;
    // number text of the item just taken, before framing
    q4ta_pkg::t_byte number_text[$];
    // bytes still owed by the block, oldest first
    t_text_beat      expected_beats[$];
    int              beats_left;
    int              mismatch_count;
    int              quiet_cycles;
    // when low, start stays high and the next item is presented as soon as the previous one is taken
    logic            idle_on;
    string           record_head;
    t_directed_row   directed_rows [NUM_ROWS];

    q4_temperature_to_ascii_record_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_temperature_q4 (i_temperature_q4),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_out_strobe     (o_out_strobe),
        .o_out_byte       (o_out_byte),
        .o_last_byte      (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // sign, integer part without leading zeros, dot, two-digit hundredths
    task automatic format_temperature(input logic signed [q4ta_pkg::TEMP_W-1:0] temp);
        logic        neg;
        logic [16:0] mag;
        int          whole;
        int          hund;
        int          nd;
        int          digits [5];
        neg   = temp[q4ta_pkg::TEMP_W-1];
        // magnitude needs 17 bits so that the most negative input fits
        mag   = neg ? (17'h10000 - {1'b0, temp}) : {1'b0, temp};
        whole = int'(mag[16:4]);
        hund  = (int'(mag[3:0]) * 625 + 50) / 100;
        nd    = 0;
        do begin
            digits[nd] = whole % 10;
            nd++;
            whole = whole / 10;
        end while (whole != 0);
        number_text.delete();
        if (neg) begin
            number_text.push_back(q4ta_pkg::CH_MINUS);
        end
        while (nd > 0) begin
            nd--;
            number_text.push_back(q4ta_pkg::CH_ZERO + q4ta_pkg::t_byte'(digits[nd]));
        end
        number_text.push_back(q4ta_pkg::CH_DOT);
        number_text.push_back(q4ta_pkg::CH_ZERO + q4ta_pkg::t_byte'(hund / 10));
        number_text.push_back(q4ta_pkg::CH_ZERO + q4ta_pkg::t_byte'(hund % 10));
    endtask

    task automatic owe_byte(input q4ta_pkg::t_byte ch);
        t_text_beat beat;
        beats_left--;
        beat.ch   = ch;
        beat.last = (beats_left == 0);
        expected_beats.push_back(beat);
    endtask

    // frames the number text as a record when wrapping is on
    task automatic owe_text(input logic wrap);
        int k;
        beats_left = number_text.size() + (wrap ? record_head.len() + 2 : 0);
        if (wrap) begin
            for (k = 0; k < record_head.len(); k++) begin
                owe_byte(q4ta_pkg::t_byte'(record_head[k]));
            end
        end
        for (k = 0; k < number_text.size(); k++) owe_byte(number_text[k]);
        if (wrap) begin
            owe_byte(q4ta_pkg::CH_RBRACE);
            owe_byte(q4ta_pkg::CH_LF);
        end
    endtask

    // presents one temperature and returns at the edge that takes it
    task automatic drive_temperature(input logic signed [q4ta_pkg::TEMP_W-1:0] temp,
                                     input string text);
        int   gap;
        int   k;
        logic after_done;
        @(negedge i_clk);
        if (idle_on) begin
            after_done = $urandom_range(0, 1);
            gap        = after_done ? $urandom_range(1, 3) : $urandom_range(0, 3);
            if (gap != 0) begin
                start <= 1'b0;
                // sometimes count the gap from the end of the previous item
                if (after_done) begin
                    while (busy) @(negedge i_clk);
                end
                repeat (gap) @(negedge i_clk);
            end
        end
        start            <= 1'b1;
        i_temperature_q4 <= temp;
        do @(posedge i_clk); while (busy);
        if (text.len() == 0) begin
            format_temperature(temp);
        end else begin
            number_text.delete();
            for (k = 0; k < text.len(); k++) begin
                number_text.push_back(q4ta_pkg::t_byte'(text[k]));
            end
        end
        owe_text(wrap_now);
    endtask

    // register writes only once the block has gone quiet
    task automatic write_wrap(input logic wrap);
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_beats.size() != 0 || busy) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wrap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        wrap_now     = wrap;
    endtask

    // mixes full-range values with the regions where the text shape changes
    function automatic logic signed [q4ta_pkg::TEMP_W-1:0] random_temperature();
        logic [q4ta_pkg::TEMP_W-1:0] u;
        logic [q4ta_pkg::TEMP_W-1:0] base;
        case ($urandom_range(0, 4))
            0: u = q4ta_pkg::TEMP_W'($urandom);
            1: u = q4ta_pkg::TEMP_W'($urandom_range(0, 511)) - 16'd256;
            2: u = 16'h8000 + q4ta_pkg::TEMP_W'($urandom_range(0, 40));
            3: u = 16'h7FFF - q4ta_pkg::TEMP_W'($urandom_range(0, 40));
            default: begin
                // around 1, 10, 100 and 1000 degrees, digit count changes there
                case ($urandom_range(0, 3))
                    0:       base = 16'd16;
                    1:       base = 16'd160;
                    2:       base = 16'd1600;
                    default: base = 16'd16000;
                endcase
                u = base + q4ta_pkg::TEMP_W'($urandom_range(0, 31)) - 16'd16;
                if ($urandom_range(0, 1) == 1) u = -u;
            end
        endcase
        return $signed(u);
    endfunction

    // result side: every strobed beat is taken at this edge
    always @(posedge i_clk) begin
        t_text_beat want;
        if (i_rst_n && o_out_strobe) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected byte 0x%02h last %0b",
                                          o_out_byte, o_last_byte));
            end else begin
                want = expected_beats.pop_front();
                if (o_out_byte !== want.ch) begin
                    report_mismatch($sformatf("byte 0x%02h, want 0x%02h",
                                              o_out_byte, want.ch));
                end
                if (o_last_byte !== want.last) begin
                    report_mismatch($sformatf("last flag %0b on byte 0x%02h, want %0b",
                                              o_last_byte, want.ch, want.last));
                end
            end
        end
    end

    // watchdog: ends a run that stops moving
    always @(posedge i_clk) begin
        if ((start && !busy) || o_out_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int   r;
        int   p;
        int   n;
        start            = 1'b0;
        i_temperature_q4 = '0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 1'b0;
        i_rst_n          = 1'b0;
        wrap_now         = 1'b1;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        beats_left       = 0;
        idle_on          = 1'b1;
        record_head      = "{\"code\":\"data\",\"value\":";

        // typed texts are the number only, the record frame is added around it
        directed_rows = '{
            // reset value of wrap_record is on
            '{1'b1, 16'sd0,       "0.00"},
            '{1'b1, 16'sd16,      "1.00"},
            '{1'b1, -16'sd1,      "-0.06"},
            '{1'b1, 16'sd32767,   "2047.94"},
            '{1'b1, -16'sd32768,  "-2048.00"},
            '{1'b1, 16'sh0155,    ""},
            // plain number
            '{1'b0, 16'sd0,       "0.00"},
            '{1'b0, -16'sd1,      "-0.06"},
            '{1'b0, -16'sd16,     "-1.00"},
            '{1'b0, 16'sd32767,   "2047.94"},
            '{1'b0, -16'sd32768,  "-2048.00"},
            '{1'b0, 16'sd160,     "10.00"},
            '{1'b0, 16'sd1600,    "100.00"},
            '{1'b0, 16'sd16000,   "1000.00"},
            '{1'b0, 16'sd8,       "0.50"},
            '{1'b0, 16'sd15,      "0.94"},
            '{1'b0, -16'sd32767,  ""},
            '{1'b0, 16'sh1234,    ""},
            '{1'b0, 16'sh0A7B,    ""},
            '{1'b0, -16'sd161,    ""},
            '{1'b0, 16'sh00C9,    ""},
            // back to the record
            '{1'b1, 16'sh4321,    ""},
            '{1'b1, -16'sd2,      ""},
            '{1'b1, 16'sh7FF0,    ""}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, register written only when a row changes framing
        for (r = 0; r < NUM_ROWS; r++) begin
            if (directed_rows[r].wrap !== wrap_now) write_wrap(directed_rows[r].wrap);
            drive_temperature(directed_rows[r].temp, directed_rows[r].text);
        end

        // random phases alternate the framing; every third runs back to back
        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_wrap(p[0]);
            idle_on = (p % 3 != 2);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                drive_temperature(random_temperature(), "");
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        // stray beats after the last expected one still get caught
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== q4_temperature_to_ascii_record_unit.f =====
+incdir+rtl
rtl/q4ta_pkg.sv
rtl/q4_temperature_to_ascii_record_unit.sv
rtl/q4ta_checker.sv
tb/q4_temperature_to_ascii_record_unit_tb.sv
